// ----- rtl/sync_word_length_deframer_assert.svh -----
// Assertion macros used by the deframer engine.
// Each macro expects clk and arst_n in the enclosing module.
`ifndef SYNC_WORD_LENGTH_DEFRAMER_ASSERT_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define SWLD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swld assertion failed");

// Next-cycle implication.
`define SWLD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swld assertion failed");

`endif

// ----- rtl/swld_pkg.sv -----
`timescale 1ns / 1ps

package swld_pkg;

	// Default geometry
	localparam int MAGIC_BYTES_DEF  = 8;
	localparam int HEADER_BYTES_DEF = 36;

	// Frame length window and header position of the length field
	localparam int LEN_MIN    = 36;
	localparam int LEN_MAX    = 65536;
	localparam int LEN_OFFSET = 12;
	localparam int LEN_W      = 17;
	localparam int BYTE_W     = 8;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;
	localparam logic REG_MAGIC = 1'b0;
	localparam logic [DATA_W-1:0] MAGIC_RESET = 64'd506660481457717506;

	// Front queue depth
	localparam int QUEUE_DEPTH = 2;

	// Head of the front queue as seen by the back end
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} swld_head_t;

	// Back-end sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ALIGN = 5'b00010,
		S_CHECK = 5'b00100,
		S_DROP  = 5'b01000,
		S_EMIT  = 5'b10000
	} swld_state_t;

endpackage

// ----- rtl/swld_front.sv -----
`timescale 1ns / 1ps

module swld_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rx_valid,
	input  logic [swld_pkg::BYTE_W-1:0]      rx_byte,
	output logic                             rx_ready,
	input  logic                             pop,
	output swld_pkg::swld_head_t             head
);
	import swld_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	logic [BYTE_W-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;
	logic              take;

	assign rx_ready   = (cnt_q != FULL);
	assign push       = rx_valid && rx_ready;
	assign take       = pop && head.valid;
	assign head.valid = (cnt_q != '0);
	assign head.data  = slot_q[rd_q];

	// Store an accepted beat
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= rx_byte;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			case ({push, take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/swld_engine.sv -----
`timescale 1ns / 1ps
`include "sync_word_length_deframer_assert.svh"

module swld_engine #(
	parameter int MAGIC_BYTES  = swld_pkg::MAGIC_BYTES_DEF,
	parameter int HEADER_BYTES = swld_pkg::HEADER_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [swld_pkg::DATA_W-1:0]       magic,
	input  swld_pkg::swld_head_t              head,
	output logic                              pop,
	output logic                              frame_valid,
	input  logic                              frame_ready,
	output logic [swld_pkg::BYTE_W-1:0]       frame_byte,
	output logic                              frame_start,
	output logic                              frame_last,
	output logic [swld_pkg::LEN_W-1:0]        frame_length
);
	import swld_pkg::*;

	localparam int CNT_W  = $clog2(HEADER_BYTES + 1);
	localparam int IDX_W  = $clog2(HEADER_BYTES);
	localparam int DROP_W = $clog2(MAGIC_BYTES + 1);
	localparam logic [CNT_W-1:0]  FULL    = CNT_W'(HEADER_BYTES);
	localparam logic [LEN_W-1:0]  HDR_LEN = LEN_W'(HEADER_BYTES);
	localparam logic [DROP_W-1:0] DROP_N  = DROP_W'(MAGIC_BYTES);

	swld_state_t       state_q;
	logic [BYTE_W-1:0] held_q [HEADER_BYTES];
	logic [CNT_W-1:0]  count_q;
	logic              in_frame_q;
	logic [LEN_W-1:0]  left_q;
	logic [LEN_W-1:0]  cur_len_q;
	logic              fits_q;
	logic              first_q;
	logic [CNT_W-1:0]  emit_q;
	logic [DROP_W-1:0] drop_q;

	logic              frame_valid_q;
	logic [BYTE_W-1:0] frame_byte_q;
	logic              frame_start_q;
	logic              frame_last_q;
	logic [LEN_W-1:0]  frame_length_q;

	logic              agree;
	logic [31:0]       len_word;
	logic [LEN_W-1:0]  len_low;
	logic              len_bad;
	logic              slot_free;
	logic              pass_go;
	logic              take_go;
	logic              emit_go;
	logic              align_go;
	logic              do_shift;
	logic              do_append;
	logic              out_load;

	// Held bytes agree with the leading sync bytes
	always_comb begin
		agree = 1'b1;
		for (int i = 0; i < MAGIC_BYTES; i++) begin
			if ((CNT_W'(i) < count_q) && (held_q[i] != magic[8*i +: 8])) begin
				agree = 1'b0;
			end
		end
	end

	// Length field, little endian
	assign len_word = {held_q[LEN_OFFSET+3], held_q[LEN_OFFSET+2],
		held_q[LEN_OFFSET+1], held_q[LEN_OFFSET]};
	assign len_low  = len_word[LEN_W-1:0];
	assign len_bad  = (len_word < 32'(LEN_MIN)) || (len_word > 32'(LEN_MAX));

	// Step decode
	assign slot_free = !frame_valid_q || frame_ready;
	assign pass_go   = (state_q == S_IDLE) && head.valid && in_frame_q && slot_free;
	assign take_go   = (state_q == S_IDLE) && head.valid && !in_frame_q;
	assign emit_go   = (state_q == S_EMIT) && slot_free;
	assign align_go  = (state_q == S_ALIGN) && (count_q != '0) && !agree;
	assign do_shift  = align_go || (state_q == S_DROP) || emit_go;
	assign do_append = take_go && (count_q != FULL);
	assign out_load  = pass_go || emit_go;
	assign pop       = pass_go || take_go;

	// Shift the held bytes down or append at the fill point
	always_ff @(posedge clk) begin
		if (do_shift) begin
			for (int i = 0; i < HEADER_BYTES - 1; i++) begin
				held_q[i] <= held_q[i+1];
			end
		end else if (do_append) begin
			held_q[count_q[IDX_W-1:0]] <= head.data;
		end
	end

	// Load the output beat
	always_ff @(posedge clk) begin
		if (out_load) begin
			frame_byte_q   <= pass_go ? head.data : held_q[0];
			frame_start_q  <= emit_go && first_q;
			frame_last_q   <= pass_go ? (left_q <= LEN_W'(1)) : (fits_q && (emit_q == CNT_W'(1)));
			frame_length_q <= cur_len_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			in_frame_q    <= 1'b0;
			left_q        <= '0;
			cur_len_q     <= '0;
			fits_q        <= 1'b0;
			first_q       <= 1'b0;
			emit_q        <= '0;
			drop_q        <= '0;
			frame_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				frame_valid_q <= 1'b1;
			end else if (frame_ready) begin
				frame_valid_q <= 1'b0;
			end

			if (do_shift) begin
				count_q <= count_q - 1'b1;
			end else if (do_append) begin
				count_q <= count_q + 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (pass_go) begin
						if (left_q != '0) begin
							left_q <= left_q - 1'b1;
						end
						if (left_q <= LEN_W'(1)) begin
							in_frame_q <= 1'b0;
						end
					end else if (take_go) begin
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					if (!align_go) begin
						state_q <= (count_q == FULL) ? S_CHECK : S_IDLE;
					end
				end
				S_CHECK: begin
					if (len_bad) begin
						drop_q  <= DROP_N;
						state_q <= S_DROP;
					end else begin
						cur_len_q <= len_low;
						first_q   <= 1'b1;
						state_q   <= S_EMIT;
						if (len_low <= HDR_LEN) begin
							fits_q <= 1'b1;
							emit_q <= len_low[CNT_W-1:0];
						end else begin
							fits_q <= 1'b0;
							emit_q <= FULL;
							left_q <= len_low - HDR_LEN;
						end
					end
				end
				S_DROP: begin
					drop_q <= drop_q - 1'b1;
					if (drop_q == DROP_W'(1)) begin
						state_q <= S_ALIGN;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						first_q <= 1'b0;
						emit_q  <= emit_q - 1'b1;
						if (emit_q == CNT_W'(1)) begin
							if (fits_q) begin
								state_q <= S_ALIGN;
							end else begin
								in_frame_q <= 1'b1;
								state_q    <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign frame_valid  = frame_valid_q;
	assign frame_byte   = frame_byte_q;
	assign frame_start  = frame_start_q;
	assign frame_last   = frame_last_q;
	assign frame_length = frame_length_q;

	// Pass-through runs with an empty header store
	`SWLD_ASSERT_IMP(a_frame_empty, in_frame_q, count_q == '0)
	// Length is only read from a full header
	`SWLD_ASSERT_IMP(a_check_full, state_q == S_CHECK, count_q == FULL)
	// Emission never runs past the held bytes
	`SWLD_ASSERT_IMP(a_emit_bound, state_q == S_EMIT, (emit_q <= count_q) && (emit_q != '0))
	// A long frame hands over to pass-through after its header
	`SWLD_ASSERT_NXT(a_enter_frame, emit_go && (emit_q == CNT_W'(1)) && !fits_q, in_frame_q && (state_q == S_IDLE))

endmodule

// ----- rtl/sync_word_length_deframer.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// rx        rx_valid / rx_ready         rx_byte
// frame     frame_valid / frame_ready   frame_byte, frame_start, frame_last, frame_length
// apb       psel, penable, pwrite/pready paddr, pwdata, prdata (magic_word at 0x0)
//
// A byte inside a frame's body passes straight to the output register; a hunted byte
// is appended, then the sync compare runs, and the realign drops leading bytes that disagree.
// A full header gets a length check, then its header bytes are emitted, or MAGIC_BYTES
// leading bytes are dropped and the header realigned when the length is out of range.
// A two-beat input queue and an output register let each side stall on its own.
// Reset clears the queue, the sequencer and the counters and restores magic_word;
// the held header bytes are not cleared.
module sync_word_length_deframer #(
	parameter int MAGIC_BYTES  = swld_pkg::MAGIC_BYTES_DEF,
	parameter int HEADER_BYTES = swld_pkg::HEADER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swld_pkg::ADDR_W-1:0]   paddr,
	input  logic [swld_pkg::DATA_W-1:0]   pwdata,
	output logic [swld_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [swld_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          frame_valid,
	input  logic                          frame_ready,
	output logic [swld_pkg::BYTE_W-1:0]   frame_byte,
	output logic                          frame_start,
	output logic                          frame_last,
	output logic [swld_pkg::LEN_W-1:0]    frame_length
);
	import swld_pkg::*;

	logic [DATA_W-1:0] magic_q;
	logic              sel_magic;
	swld_head_t        head;
	logic              pop;

	// Register decode
	assign sel_magic = (paddr[ADDR_W-1] == REG_MAGIC);
	assign pready    = 1'b1;
	assign prdata    = sel_magic ? magic_q : '0;

	// Hold the sync word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (psel && penable && pwrite && pready && sel_magic) begin
			magic_q <= pwdata;
		end
	end

	swld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.rx_ready (rx_ready),
		.pop      (pop),
		.head     (head)
	);

	swld_engine #(
		.MAGIC_BYTES  (MAGIC_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.magic        (magic_q),
		.head         (head),
		.pop          (pop),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame_byte   (frame_byte),
		.frame_start  (frame_start),
		.frame_last   (frame_last),
		.frame_length (frame_length)
	);

endmodule

// ----- verif/sync_word_length_deframer_tb.sv -----
`timescale 1ns / 1ps

module sync_word_length_deframer_tb;
	import swld_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int NUM_SYNC = MAGIC_BYTES_DEF;
	localparam int NUM_HDR = HEADER_BYTES_DEF;
	localparam logic [ADDR_W-1:0] MAGIC_ADDR = ADDR_W'(8 * REG_MAGIC);
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [63:0] SYNC_OVERLAP = 64'hABAA_AAAA_AAAA_AAAA;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              start;
		logic              last;
		logic [LEN_W-1:0]  len;
	} frame_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic rx_valid = 1'b0;
	logic rx_ready;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic frame_valid;
	logic frame_ready = 1'b0;
	logic [BYTE_W-1:0] frame_byte;
	logic frame_start;
	logic frame_last;
	logic [LEN_W-1:0] frame_length;

	int send_idle_pct = 0;
	int ready_stall_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	// Deframer state as predicted by the testbench
	logic [63:0] sync_word = MAGIC_RESET;
	logic [BYTE_W-1:0] hdr_buf [NUM_HDR];
	int unsigned hdr_fill = 0;
	bit in_body = 1'b0;
	int unsigned body_left = 0;
	logic [LEN_W-1:0] body_len = '0;

	frame_beat_t frames_due [$];
	frame_beat_t due_beat;
	logic [BYTE_W-1:0] stim_q [$];

	sync_word_length_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame_byte   (frame_byte),
		.frame_start  (frame_start),
		.frame_last   (frame_last),
		.frame_length (frame_length)
	);

	always #CLK_HALF clk = ~clk;

	// Stall the frame side at the current rate
	always @(posedge clk) begin
		frame_ready <= (ready_stall_pct == 0) || ($urandom_range(99) >= ready_stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** sync_word_length_deframer: FAILED **");
			$finish;
		end
	end

	// Held bytes must agree with the leading sync bytes
	function automatic bit hdr_agrees();
		int unsigned n;
		n = (hdr_fill < NUM_SYNC) ? hdr_fill : NUM_SYNC;
		for (int unsigned i = 0; i < n; i++)
			if (hdr_buf[i] != sync_word[8*i +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void hdr_drop(int unsigned k);
		if (k >= hdr_fill) begin
			hdr_fill = 0;
		end else begin
			for (int unsigned i = 0; i + k < hdr_fill; i++)
				hdr_buf[i] = hdr_buf[i + k];
			hdr_fill -= k;
		end
	endfunction

	function automatic void hdr_resync();
		while (hdr_fill > 0 && !hdr_agrees())
			hdr_drop(1);
	endfunction

	function automatic void expect_beat(logic [BYTE_W-1:0] data, bit start, bit last);
		frame_beat_t beat;
		beat.data = data;
		beat.start = start;
		beat.last = last;
		beat.len = body_len;
		frames_due.push_back(beat);
	endfunction

	// Advance the predicted deframer by one received byte
	function automatic void predict_rx(logic [BYTE_W-1:0] data);
		logic [31:0] len_field;
		int unsigned n;
		if (in_body) begin
			expect_beat(data, 1'b0, body_left <= 1);
			if (body_left > 0)
				body_left--;
			if (body_left == 0)
				in_body = 1'b0;
			return;
		end
		if (hdr_fill < NUM_HDR) begin
			hdr_buf[hdr_fill] = data;
			hdr_fill++;
		end
		hdr_resync();
		if (hdr_fill < NUM_HDR)
			return;
		len_field = {hdr_buf[LEN_OFFSET+3], hdr_buf[LEN_OFFSET+2],
			hdr_buf[LEN_OFFSET+1], hdr_buf[LEN_OFFSET]};
		// Out-of-range length: drop the sync word only and rescan
		if (len_field < LEN_MIN || len_field > LEN_MAX) begin
			hdr_drop(NUM_SYNC);
			hdr_resync();
			return;
		end
		body_len = len_field[LEN_W-1:0];
		n = (len_field < hdr_fill) ? len_field : hdr_fill;
		for (int unsigned i = 0; i < n; i++)
			expect_beat(hdr_buf[i], i == 0, i + 1 == len_field);
		if (len_field > n) begin
			body_left = len_field - n;
			in_body = 1'b1;
			hdr_fill = 0;
		end else begin
			hdr_drop(n);
			hdr_resync();
		end
	endfunction

	// Check each frame beat, then predict from each accepted rx beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_valid && frame_ready) begin
				if (frames_due.size() == 0) begin
					$error("frame beat with nothing expected: frame_byte %02h", frame_byte);
					fail_count++;
				end else begin
					due_beat = frames_due.pop_front();
					if (frame_byte !== due_beat.data) begin
						$error("frame_byte: expected %02h, got %02h", due_beat.data, frame_byte);
						fail_count++;
					end
					if (frame_start !== due_beat.start) begin
						$error("frame_start: expected %0b, got %0b", due_beat.start, frame_start);
						fail_count++;
					end
					if (frame_last !== due_beat.last) begin
						$error("frame_last: expected %0b, got %0b", due_beat.last, frame_last);
						fail_count++;
					end
					if (frame_length !== due_beat.len) begin
						$error("frame_length: expected %0d, got %0d", due_beat.len,
							frame_length);
						fail_count++;
					end
				end
			end
			if (rx_valid && rx_ready)
				predict_rx(rx_byte);
		end
	end

	// Stimulus builders
	function automatic void add_noise(int n);
		for (int i = 0; i < n; i++)
			stim_q.push_back(BYTE_W'($urandom_range(255)));
	endfunction

	function automatic void add_sync(int n);
		for (int i = 0; i < n; i++)
			stim_q.push_back(sync_word[8*i +: 8]);
	endfunction

	function automatic void add_le32(logic [31:0] value);
		for (int i = 0; i < 4; i++)
			stim_q.push_back(value[8*i +: 8]);
	endfunction

	function automatic void add_hdr_tail(logic [31:0] len_field);
		add_noise(LEN_OFFSET - NUM_SYNC);
		add_le32(len_field);
		add_noise(NUM_HDR - LEN_OFFSET - 4);
	endfunction

	function automatic void add_frame(logic [31:0] len_field);
		add_sync(NUM_SYNC);
		add_hdr_tail(len_field);
		if (len_field >= LEN_MIN && len_field <= LEN_MAX)
			add_noise(len_field - NUM_HDR);
	endfunction

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		ready_stall_pct = stall_pct;
	endtask

	// Hold each byte until accepted; idle in between at the current rate
	task automatic send_byte(input logic [BYTE_W-1:0] value);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= value;
		do @(posedge clk); while (!rx_ready);
	endtask

	task automatic send_stim();
		while (stim_q.size() > 0)
			send_byte(stim_q.pop_front());
	endtask

	// Drop valid, drain all expected beats, then let the hunt settle
	task automatic wait_idle();
		rx_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_magic(input logic [63:0] expected);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MAGIC_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== expected) begin
			$error("magic_word: expected %016h, got %016h", expected, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_magic(input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAGIC_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sync_word = value;
		read_magic(value);
	endtask

	task automatic test_reset_value();
		read_magic(MAGIC_RESET);
	endtask

	// Partial sync words; the trailing partial match stays held for the next test
	task automatic test_partial_sync();
		set_idling(0, 0);
		add_noise(3);
		add_sync(5);
		add_noise(1);
		add_sync(3);
		send_stim();
		wait_idle();
	endtask

	// Lengths just below and just above the window, each header carrying the next
	// sync word after its length field, then a frame of the minimum length
	task automatic test_length_bounds();
		set_idling(29, 29);
		add_sync(NUM_SYNC);
		add_noise(LEN_OFFSET - NUM_SYNC);
		add_le32(LEN_MIN - 1);
		add_sync(NUM_SYNC);
		add_noise(LEN_OFFSET - NUM_SYNC);
		add_le32(LEN_MAX + 1);
		add_frame(LEN_MIN);
		send_stim();
		wait_idle();
	endtask

	// Second sync word right after the first: the first length lands on sync bytes 4..7,
	// which is out of range for the reset word, so the rescan must find the second header
	task automatic test_rescan_after_bad_length();
		set_idling(63, 0);
		add_sync(NUM_SYNC);
		add_sync(NUM_SYNC);
		add_noise(4);
		add_le32(LEN_MIN);
		add_noise(NUM_HDR - 16);
		send_stim();
		wait_idle();
	endtask

	// Self-overlapping sync word behind a run of its own leading bytes
	task automatic test_sync_word_extremes();
		set_idling(0, 63);
		write_magic(SYNC_OVERLAP);
		add_sync(NUM_SYNC - 1);
		add_frame(LEN_MIN);
		send_stim();
		wait_idle();
		write_magic(MAGIC_RESET);
	endtask

	// Maximum length is accepted; a sync word inside the body passes through untouched
	task automatic test_longest_frame();
		set_idling(0, 0);
		add_sync(NUM_SYNC);
		add_hdr_tail(LEN_MAX);
		add_sync(NUM_SYNC);
		send_stim();
		wait_idle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_value();
		test_partial_sync();
		test_length_bounds();
		test_rescan_after_bad_length();
		test_sync_word_extremes();
		test_longest_frame();
		if (fail_count == 0)
			$display("** sync_word_length_deframer: PASSED **");
		else
			$display("** sync_word_length_deframer: FAILED **");
		$finish;
	end

endmodule
